// ===== src/page_framebuffer_drawing_engine_defines.svh =====
// Assertion macros for the page framebuffer drawing engine.
// Used by the top level; expects signals named clk and rst_n in scope.
`ifndef PAGE_FRAMEBUFFER_DRAWING_ENGINE_DEFINES_SVH
`define PAGE_FRAMEBUFFER_DRAWING_ENGINE_DEFINES_SVH

// Checked only outside reset.
`define PFDE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Checked at every edge, reset included.
`define PFDE_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/pfde_pkg.sv =====
// Shared types, constants and address helpers for the page framebuffer engine.
// No dependencies; the design modules refer to it by scoped names.
package pfde_pkg;

  // Panel geometry and page layout
  localparam int PANEL_WIDTH  = 128;
  localparam int PANEL_HEIGHT = 64;
  localparam int PAGE_ROWS    = 8;
  localparam int PAGE_COUNT   = (PANEL_HEIGHT + PAGE_ROWS - 1) / PAGE_ROWS;
  localparam int STORE_BYTES  = PANEL_WIDTH * PAGE_COUNT;
  localparam int ADDR_W       = $clog2(STORE_BYTES);
  localparam int BYTE_BITS    = 8;
  localparam int CNT_W        = $clog2(BYTE_BITS + 1);
  localparam logic [7:0] MSB_MASK = 8'h80;

  // Input word field widths
  localparam int OP_W   = 3;
  localparam int X_W    = 7;
  localparam int Y_W    = 6;
  localparam int WD_W   = 8;
  localparam int HT_W   = 7;
  localparam int IDX_W  = 10;
  localparam int IN_BITS = X_W + Y_W + WD_W + HT_W + 1 + 8 + IDX_W;
  localparam int TDATA_W = ((IN_BITS + 7) / 8) * 8;

  // Internal coordinate widths (origin plus offset)
  localparam int PX_W = 9;
  localparam int PY_W = 8;

  typedef enum logic [OP_W-1:0] {
    OP_SET_PIXEL   = 3'd0,
    OP_READ_PIXEL  = 3'd1,
    OP_READ_BYTE   = 3'd2,
    OP_FILL_RECT   = 3'd3,
    OP_START_BLIT  = 3'd4,
    OP_BLIT_DATA   = 3'd5
  } op_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FILL,
    ST_BIT,
    ST_RD,
    ST_WR,
    ST_RESP
  } state_t;

  typedef enum logic [2:0] {
    JOB_SET,
    JOB_FILL,
    JOB_BLIT,
    JOB_RD_PIX,
    JOB_RD_BYTE
  } job_t;

  typedef struct packed {
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [7:0]        wr_data;
  } mem_req_t;

  typedef struct packed {
    logic       vld;
    logic [7:0] value;
  } res_t;

  // Pixel lies on the panel
  function automatic logic on_panel(logic [PX_W-1:0] px, logic [PY_W-1:0] py);
    return (32'(px) < PANEL_WIDTH) && (32'(py) < PANEL_HEIGHT);
  endfunction

  // Store byte holding pixel (px, py); only meaningful on the panel
  function automatic logic [ADDR_W-1:0] page_addr(logic [PX_W-1:0] px,
                                                  logic [PY_W-1:0] py);
    return ADDR_W'((32'(py) / PAGE_ROWS) * PANEL_WIDTH + 32'(px));
  endfunction

endpackage

// ===== src/page_framebuffer_drawing_engine.sv =====
// Flow: set pixel reads, then writes its byte if on the panel; read pixel and read byte
// read their byte and pass a result word on, zero if off the panel or out of range. Fill does a
// read-modify-write per store byte touched and a step per column; blit data does one per
// on-panel bit and skips clipped bits. One word at a time, one shared read-modify-write;
// in_tready is high only while idle, and a read waits while the result register stays full.
// Reset (rst_n low, synchronous): store cleared one byte a cycle, 1024 bytes, in_tready low.
`include "page_framebuffer_drawing_engine_defines.svh"

// Top level: frame store, sequencer and the result register.
// Depends on pfde_pkg, pfde_ram, pfde_seq and the defines header.
module page_framebuffer_drawing_engine (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  // in_tdata from bit 0: x[6:0], y[12:7], width[20:13], height[27:21],
  // pixel_on[28], data_byte[36:29], byte_index[46:37], zero[47]
  input  logic [pfde_pkg::TDATA_W-1:0] in_tdata,
  // in_tuser: op[2:0]
  input  logic [pfde_pkg::OP_W-1:0]    in_tuser,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  // out_tdata: read_value[7:0]
  output logic [7:0]                   out_tdata
);

  pfde_pkg::mem_req_t mem_req;
  pfde_pkg::res_t     res;
  logic [7:0]         mem_rdata;
  logic               res_free;
  logic               out_tvalid_r;
  logic [7:0]         out_tdata_r;

  pfde_ram u_ram (
    .clk     (clk),
    .mem_req (mem_req),
    .rdata   (mem_rdata)
  );

  pfde_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata),
    .res       (res),
    .res_free  (res_free)
  );

  // Result register: takes a new word when empty or being drained
  assign res_free = !out_tvalid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (res_free) begin
      out_tvalid_r <= res.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (res_free && res.vld) begin
      out_tdata_r <= res.value;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // Checks
  `PFDE_ASSERT_ALWAYS(a_clear_after_reset, !rst_n |=> !in_tready, "word taken during clear pass")
  `PFDE_ASSERT(a_result_source, $rose(out_tvalid) |-> $past(res.vld), "result word not from sequencer")
  `PFDE_ASSERT(a_idle_no_write, in_tready |-> !mem_req.wr_en, "store written while idle")

endmodule

// ===== src/pfde_ram.sv =====
// Frame store: one write port and one registered read port.
// Depends on pfde_pkg for depth, address width and the request struct.
module pfde_ram (
  input  logic               clk,
  input  pfde_pkg::mem_req_t mem_req,
  output logic [7:0]         rdata
);

  logic [7:0] mem [pfde_pkg::STORE_BYTES];
  logic [7:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (mem_req.wr_en) begin
      mem[mem_req.wr_addr] <= mem_req.wr_data;
    end
  end

  // Read port, data held until the next read
  always_ff @(posedge clk) begin
    if (mem_req.rd_en) begin
      rdata_r <= mem[mem_req.rd_addr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== src/pfde_seq.sv =====
// Sequencer and shared read-modify-write unit of the drawing engine.
// Depends on pfde_pkg; drives the frame store through a pfde_pkg::mem_req_t.
module pfde_seq (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [pfde_pkg::TDATA_W-1:0] in_tdata,
  input  logic [pfde_pkg::OP_W-1:0]    in_tuser,
  output pfde_pkg::mem_req_t           mem_req,
  input  logic [7:0]                   mem_rdata,
  output pfde_pkg::res_t               res,
  input  logic                         res_free
);

  localparam int PX_W = pfde_pkg::PX_W;
  localparam int PY_W = pfde_pkg::PY_W;
  localparam int ADDR_W = pfde_pkg::ADDR_W;

  // Input word fields
  logic                       acc;
  pfde_pkg::op_t              in_op;
  logic [pfde_pkg::X_W-1:0]   f_x;
  logic [pfde_pkg::Y_W-1:0]   f_y;
  logic [pfde_pkg::WD_W-1:0]  f_w;
  logic [pfde_pkg::HT_W-1:0]  f_h;
  logic                       f_on;
  logic [7:0]                 f_data;
  logic [pfde_pkg::IDX_W-1:0] f_idx;

  assign f_x    = in_tdata[6:0];
  assign f_y    = in_tdata[12:7];
  assign f_w    = in_tdata[20:13];
  assign f_h    = in_tdata[27:21];
  assign f_on   = in_tdata[28];
  assign f_data = in_tdata[36:29];
  assign f_idx  = in_tdata[46:37];
  assign in_op  = pfde_pkg::op_t'(in_tuser);
  assign acc    = in_tvalid && in_tready;

  // Control state
  pfde_pkg::state_t           state_r, state_nxt;
  logic [ADDR_W-1:0]          clr_addr_r;
  logic [pfde_pkg::X_W-1:0]   origin_col_r;
  logic [pfde_pkg::Y_W-1:0]   origin_row_r;
  logic [pfde_pkg::WD_W-1:0]  blit_w_r;
  logic [pfde_pkg::HT_W-1:0]  blit_h_r;
  logic [pfde_pkg::WD_W-1:0]  cur_col_r;
  logic [pfde_pkg::HT_W-1:0]  cur_row_r;
  logic                       blit_active_r;
  logic [pfde_pkg::CNT_W-1:0] bit_cnt_r;

  // Work registers
  pfde_pkg::job_t             job_r;
  logic [ADDR_W-1:0]          addr_r;
  logic [7:0]                 mask_r;
  logic                       lit_r;
  logic [2:0]                 bitsel_r;
  logic                       zero_r;
  logic [PX_W-1:0]            cx_r;
  logic [PY_W-1:0]            ry_r;
  logic [PY_W-1:0]            y0_r;
  logic [PX_W-1:0]            x_end_r;
  logic [PY_W-1:0]            y_end_r;
  logic [7:0]                 data_r;

  // Item decode helpers
  logic            f_on_panel;
  logic [PX_W-1:0] sum_x, x_end_c;
  logic [PY_W-1:0] sum_y, y_end_c;
  logic            fill_ok;
  logic            idx_ok;

  assign f_on_panel = pfde_pkg::on_panel(PX_W'(f_x), PY_W'(f_y));
  assign sum_x   = PX_W'(f_x) + PX_W'(f_w);
  assign sum_y   = PY_W'(f_y) + PY_W'(f_h);
  assign x_end_c = (sum_x > PX_W'(pfde_pkg::PANEL_WIDTH)) ?
                   PX_W'(pfde_pkg::PANEL_WIDTH) : sum_x;
  assign y_end_c = (sum_y > PY_W'(pfde_pkg::PANEL_HEIGHT)) ?
                   PY_W'(pfde_pkg::PANEL_HEIGHT) : sum_y;
  assign fill_ok = (f_w != '0) && (f_h != '0) && f_on_panel;
  assign idx_ok  = 32'(f_idx) < pfde_pkg::STORE_BYTES;

  // Blit pixel under the cursor and the cursor step
  logic [PX_W-1:0] b_px, col_inc;
  logic [PY_W-1:0] b_py, row_inc;
  logic            b_on, col_wrap, bits_done;

  assign b_px      = PX_W'(origin_col_r) + PX_W'(cur_col_r);
  assign b_py      = PY_W'(origin_row_r) + PY_W'(cur_row_r);
  assign b_on      = pfde_pkg::on_panel(b_px, b_py);
  assign col_inc   = PX_W'(cur_col_r) + PX_W'(1);
  assign row_inc   = PY_W'(cur_row_r) + PY_W'(1);
  assign col_wrap  = col_inc >= PX_W'(blit_w_r);
  assign bits_done = (bit_cnt_r == pfde_pkg::CNT_W'(pfde_pkg::BYTE_BITS)) ||
                     !blit_active_r;

  // Fill: rows of the current page still inside the rectangle
  logic [7:0]      fill_mask;
  logic [PY_W-1:0] ry_next_page;
  logic            fill_col_done, fill_all_done;

  always_comb begin
    for (int b = 0; b < 8; b++) begin
      fill_mask[b] = (3'(b) >= ry_r[2:0]) && ({ry_r[PY_W-1:3], 3'(b)} < y_end_r);
    end
  end

  assign ry_next_page  = {ry_r[PY_W-1:3] + (PY_W-3)'(1), 3'b000};
  assign fill_all_done = cx_r >= x_end_r;
  assign fill_col_done = ry_r >= y_end_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pfde_pkg::ST_CLEAR: begin
        if (clr_addr_r == ADDR_W'(pfde_pkg::STORE_BYTES - 1)) begin
          state_nxt = pfde_pkg::ST_IDLE;
        end
      end
      pfde_pkg::ST_IDLE: begin
        if (acc) begin
          unique case (in_op)
            pfde_pkg::OP_SET_PIXEL: begin
              if (f_on_panel) state_nxt = pfde_pkg::ST_RD;
            end
            pfde_pkg::OP_READ_PIXEL: begin
              state_nxt = f_on_panel ? pfde_pkg::ST_RD : pfde_pkg::ST_RESP;
            end
            pfde_pkg::OP_READ_BYTE: begin
              state_nxt = idx_ok ? pfde_pkg::ST_RD : pfde_pkg::ST_RESP;
            end
            pfde_pkg::OP_FILL_RECT: begin
              if (fill_ok) state_nxt = pfde_pkg::ST_FILL;
            end
            pfde_pkg::OP_BLIT_DATA: begin
              if (blit_active_r) state_nxt = pfde_pkg::ST_BIT;
            end
            default: state_nxt = pfde_pkg::ST_IDLE;
          endcase
        end
      end
      pfde_pkg::ST_FILL: begin
        if (fill_all_done) begin
          state_nxt = pfde_pkg::ST_IDLE;
        end else if (!fill_col_done) begin
          state_nxt = pfde_pkg::ST_RD;
        end
      end
      pfde_pkg::ST_BIT: begin
        if (bits_done) begin
          state_nxt = pfde_pkg::ST_IDLE;
        end else if (b_on) begin
          state_nxt = pfde_pkg::ST_RD;
        end
      end
      pfde_pkg::ST_RD: begin
        if (job_r == pfde_pkg::JOB_RD_PIX || job_r == pfde_pkg::JOB_RD_BYTE) begin
          state_nxt = pfde_pkg::ST_RESP;
        end else begin
          state_nxt = pfde_pkg::ST_WR;
        end
      end
      pfde_pkg::ST_WR: begin
        unique case (job_r)
          pfde_pkg::JOB_FILL: state_nxt = pfde_pkg::ST_FILL;
          pfde_pkg::JOB_BLIT: state_nxt = pfde_pkg::ST_BIT;
          default:            state_nxt = pfde_pkg::ST_IDLE;
        endcase
      end
      pfde_pkg::ST_RESP: begin
        if (res_free) state_nxt = pfde_pkg::ST_IDLE;
      end
      default: state_nxt = pfde_pkg::ST_IDLE;
    endcase
  end

  // Outputs: handshake, store access, result
  always_comb begin
    in_tready = (state_r == pfde_pkg::ST_IDLE);
    mem_req   = '0;
    res       = '0;
    unique case (state_r)
      pfde_pkg::ST_CLEAR: begin
        mem_req.wr_en   = 1'b1;
        mem_req.wr_addr = clr_addr_r;
      end
      pfde_pkg::ST_RD: begin
        mem_req.rd_en   = 1'b1;
        mem_req.rd_addr = addr_r;
      end
      pfde_pkg::ST_WR: begin
        // shared merge: set or clear the masked bits
        mem_req.wr_en   = 1'b1;
        mem_req.wr_addr = addr_r;
        mem_req.wr_data = lit_r ? (mem_rdata | mask_r) : (mem_rdata & ~mask_r);
      end
      pfde_pkg::ST_RESP: begin
        res.vld = 1'b1;
        if (zero_r) begin
          res.value = '0;
        end else if (job_r == pfde_pkg::JOB_RD_PIX) begin
          res.value = {7'b0, mem_rdata[bitsel_r]};
        end else begin
          res.value = mem_rdata;
        end
      end
      default: begin
        res = '0;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= pfde_pkg::ST_CLEAR;
      clr_addr_r    <= '0;
      origin_col_r  <= '0;
      origin_row_r  <= '0;
      blit_w_r      <= '0;
      blit_h_r      <= '0;
      cur_col_r     <= '0;
      cur_row_r     <= '0;
      blit_active_r <= 1'b0;
      bit_cnt_r     <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == pfde_pkg::ST_CLEAR) begin
        clr_addr_r <= clr_addr_r + ADDR_W'(1);
      end
      // open a blit
      if (acc && in_op == pfde_pkg::OP_START_BLIT) begin
        origin_col_r  <= f_x;
        origin_row_r  <= f_y;
        blit_w_r      <= f_w;
        blit_h_r      <= f_h;
        cur_col_r     <= '0;
        cur_row_r     <= '0;
        blit_active_r <= (f_w != '0) && (f_h != '0);
      end
      if (acc && in_op == pfde_pkg::OP_BLIT_DATA) begin
        bit_cnt_r <= '0;
      end
      // one bitmap bit: step the cursor
      if (state_r == pfde_pkg::ST_BIT && !bits_done) begin
        bit_cnt_r <= bit_cnt_r + pfde_pkg::CNT_W'(1);
        if (col_wrap) begin
          cur_col_r     <= '0;
          cur_row_r     <= row_inc[pfde_pkg::HT_W-1:0];
          blit_active_r <= row_inc < PY_W'(blit_h_r);
        end else begin
          cur_col_r <= col_inc[pfde_pkg::WD_W-1:0];
        end
      end
    end
  end

  // Work registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      pfde_pkg::ST_IDLE: begin
        if (acc) begin
          unique case (in_op)
            pfde_pkg::OP_SET_PIXEL: begin
              job_r  <= pfde_pkg::JOB_SET;
              addr_r <= pfde_pkg::page_addr(PX_W'(f_x), PY_W'(f_y));
              mask_r <= 8'h01 << f_y[2:0];
              lit_r  <= f_on;
            end
            pfde_pkg::OP_READ_PIXEL: begin
              job_r    <= pfde_pkg::JOB_RD_PIX;
              addr_r   <= pfde_pkg::page_addr(PX_W'(f_x), PY_W'(f_y));
              bitsel_r <= f_y[2:0];
              zero_r   <= !f_on_panel;
            end
            pfde_pkg::OP_READ_BYTE: begin
              job_r  <= pfde_pkg::JOB_RD_BYTE;
              addr_r <= ADDR_W'(f_idx);
              zero_r <= !idx_ok;
            end
            pfde_pkg::OP_FILL_RECT: begin
              job_r   <= pfde_pkg::JOB_FILL;
              lit_r   <= 1'b1;
              cx_r    <= PX_W'(f_x);
              ry_r    <= PY_W'(f_y);
              y0_r    <= PY_W'(f_y);
              x_end_r <= x_end_c;
              y_end_r <= y_end_c;
            end
            pfde_pkg::OP_BLIT_DATA: begin
              job_r  <= pfde_pkg::JOB_BLIT;
              data_r <= f_data;
            end
            default: begin
              zero_r <= zero_r;
            end
          endcase
        end
      end
      pfde_pkg::ST_FILL: begin
        if (!fill_all_done) begin
          if (fill_col_done) begin
            // next column, back to the top row
            cx_r <= cx_r + PX_W'(1);
            ry_r <= y0_r;
          end else begin
            addr_r <= pfde_pkg::page_addr(cx_r, ry_r);
            mask_r <= fill_mask;
            ry_r   <= ry_next_page;
          end
        end
      end
      pfde_pkg::ST_BIT: begin
        if (!bits_done) begin
          addr_r <= pfde_pkg::page_addr(b_px, b_py);
          mask_r <= 8'h01 << b_py[2:0];
          lit_r  <= (data_r & pfde_pkg::MSB_MASK) != '0;
          data_r <= data_r << 1;
        end
      end
      default: begin
        zero_r <= zero_r;
      end
    endcase
  end

endmodule
